@@ rtl/ecl_pkg.sv @@
`timescale 1ns / 1ps

package ecl_pkg;

    typedef logic [3:0] tk_t;

    localparam tk_t TK_NUM      = 4'd0;
    localparam tk_t TK_PLUS     = 4'd1;
    localparam tk_t TK_MINUS    = 4'd2;
    localparam tk_t TK_MUL      = 4'd3;
    localparam tk_t TK_DIV      = 4'd4;
    localparam tk_t TK_LPAR     = 4'd5;
    localparam tk_t TK_RPAR     = 4'd6;
    localparam tk_t TK_POW      = 4'd7;
    localparam tk_t TK_SIN      = 4'd8;
    localparam tk_t TK_COS      = 4'd9;
    localparam tk_t TK_TAN      = 4'd10;
    localparam tk_t TK_LOG      = 4'd11;
    localparam tk_t TK_LN       = 4'd12;
    localparam tk_t TK_ERROR    = 4'd13;
    localparam tk_t TK_END_OK   = 4'd14;
    localparam tk_t TK_END_FAIL = 4'd15;

    localparam int VALUE_BITS = 32;

    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_Z      = 8'h7a;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_CARET  = 8'h5e;

    // letter codes relative to 'a'
    localparam logic [4:0] LT_A = 5'd0;
    localparam logic [4:0] LT_C = 5'd2;
    localparam logic [4:0] LT_G = 5'd6;
    localparam logic [4:0] LT_I = 5'd8;
    localparam logic [4:0] LT_L = 5'd11;
    localparam logic [4:0] LT_N = 5'd13;
    localparam logic [4:0] LT_O = 5'd14;
    localparam logic [4:0] LT_S = 5'd18;
    localparam logic [4:0] LT_T = 5'd19;

    localparam logic [2:0] LEN_TOO_LONG = 3'd4;

    // up to three tokens produced by one request
    typedef struct packed {
        logic [1:0]            count;
        tk_t                   kind0;
        tk_t                   kind1;
        tk_t                   kind2;
        logic [VALUE_BITS-1:0] num;
    } tok_set_t;

    function automatic logic is_op(input logic [7:0] c);
        logic r;
        unique case (c)
            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
            CH_LPAR, CH_RPAR, CH_CARET: r = 1'b1;
            default:                    r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic tk_t op_kind(input logic [7:0] c);
        tk_t k;
        unique case (c)
            CH_PLUS:  k = TK_PLUS;
            CH_MINUS: k = TK_MINUS;
            CH_STAR:  k = TK_MUL;
            CH_SLASH: k = TK_DIV;
            CH_LPAR:  k = TK_LPAR;
            CH_RPAR:  k = TK_RPAR;
            CH_CARET: k = TK_POW;
            default:  k = TK_ERROR;
        endcase
        return k;
    endfunction

    function automatic tk_t match_name(input logic [4:0] l0, input logic [4:0] l1,
                                       input logic [4:0] l2, input logic [2:0] len);
        tk_t k;
        priority if (len == 3'd3 && l0 == LT_S && l1 == LT_I && l2 == LT_N) k = TK_SIN;
        else if (len == 3'd3 && l0 == LT_C && l1 == LT_O && l2 == LT_S) k = TK_COS;
        else if (len == 3'd3 && l0 == LT_T && l1 == LT_A && l2 == LT_N) k = TK_TAN;
        else if (len == 3'd3 && l0 == LT_L && l1 == LT_O && l2 == LT_G) k = TK_LOG;
        else if (len == 3'd2 && l0 == LT_L && l1 == LT_N) k = TK_LN;
        else k = TK_ERROR;
        return k;
    endfunction

endpackage

@@ rtl/ecl_core.sv @@
`timescale 1ns / 1ps

module ecl_core
    import ecl_pkg::*;
#(
    parameter int NUMBER_BITS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic       action,
    input  logic [7:0] char_code,
    output tok_set_t   toks
);

    logic [NUMBER_BITS-1:0] acc_reg, acc_next;
    logic                   pend_reg, pend_next;
    logic [4:0]             let_reg [3], let_next [3];
    logic [2:0]             len_reg, len_next;
    logic                   err_reg, err_next;

    logic [NUMBER_BITS+3:0]  acc_x10;
    logic [3:0]              digit;
    logic [NUMBER_BITS+31:0] acc_ext;
    logic                    is_digit;
    logic                    is_letter;
    tk_t                     fn_kind;
    tk_t                     kinds [3];
    logic [1:0]              n;

    assign is_digit  = (char_code >= CH_0) && (char_code <= CH_9);
    assign is_letter = (char_code >= CH_A) && (char_code <= CH_Z);
    assign digit     = 4'(char_code - CH_0);
    assign acc_x10   = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                       + (NUMBER_BITS+4)'(digit);
    assign acc_ext   = {32'b0, acc_reg};
    assign fn_kind   = match_name(let_reg[0], let_reg[1], let_reg[2], len_reg);

    always_comb
    begin
        acc_next  = acc_reg;
        pend_next = pend_reg;
        let_next  = let_reg;
        len_next  = len_reg;
        err_next  = err_reg;
        kinds[0]  = TK_NUM;
        kinds[1]  = TK_NUM;
        kinds[2]  = TK_NUM;
        n         = 2'd0;
        toks.num  = '0;

        if (action)
        begin
            if (!err_reg && pend_reg)
            begin
                kinds[n] = TK_NUM;
                toks.num = acc_ext[VALUE_BITS-1:0];
                n        = n + 2'd1;
            end
            kinds[n]  = err_reg ? TK_END_FAIL : TK_END_OK;
            n         = n + 2'd1;
            acc_next  = '0;
            pend_next = 1'b0;
            let_next  = '{default: '0};
            len_next  = 3'd0;
            err_next  = 1'b0;
        end
        else if (!err_reg)
        begin
            if (is_digit)
            begin
                // saturate when the product leaves the number range
                if (acc_x10[NUMBER_BITS+3:NUMBER_BITS] != 4'd0)
                    acc_next = '1;
                else
                    acc_next = acc_x10[NUMBER_BITS-1:0];
                pend_next = 1'b1;
            end
            else
            begin
                if (pend_reg)
                begin
                    kinds[n]  = TK_NUM;
                    toks.num  = acc_ext[VALUE_BITS-1:0];
                    n         = n + 2'd1;
                    acc_next  = '0;
                    pend_next = 1'b0;
                end
                if (is_letter)
                begin
                    if (len_reg < 3'd3)
                    begin
                        let_next[len_reg[1:0]] = 5'(char_code - CH_A);
                        len_next               = len_reg + 3'd1;
                    end
                    else
                        len_next = LEN_TOO_LONG;
                end
                else if (!is_op(char_code))
                begin
                    kinds[n] = TK_ERROR;
                    n        = n + 2'd1;
                    err_next = 1'b1;
                end
                else if (len_reg != 3'd0 && fn_kind == TK_ERROR)
                begin
                    kinds[n] = TK_ERROR;
                    n        = n + 2'd1;
                    err_next = 1'b1;
                end
                else
                begin
                    if (len_reg != 3'd0)
                    begin
                        kinds[n] = fn_kind;
                        n        = n + 2'd1;
                        let_next = '{default: '0};
                        len_next = 3'd0;
                    end
                    kinds[n] = op_kind(char_code);
                    n        = n + 2'd1;
                end
            end
        end

        toks.count = n;
        toks.kind0 = kinds[0];
        toks.kind1 = kinds[1];
        toks.kind2 = kinds[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            pend_reg <= 1'b0;
            let_reg  <= '{default: '0};
            len_reg  <= 3'd0;
            err_reg  <= 1'b0;
        end
        else if (step)
        begin
            acc_reg  <= acc_next;
            pend_reg <= pend_next;
            let_reg  <= let_next;
            len_reg  <= len_next;
            err_reg  <= err_next;
        end
    end

    a_err_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> !pend_reg)
        else $error("pending number while in error");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_TOO_LONG)
        else $error("letter count out of range");

    a_idle_acc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !pend_reg |-> acc_reg == '0)
        else $error("number accumulator not cleared");

endmodule

@@ rtl/ecl_token_buf.sv @@
`timescale 1ns / 1ps

module ecl_token_buf
    import ecl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  tok_set_t              toks,
    output logic                  free,
    output logic                  valid,
    input  logic                  ready,
    output tk_t                   kind,
    output logic [VALUE_BITS-1:0] num,
    output logic                  last
);

    tk_t                   kind_reg [3];
    logic [VALUE_BITS-1:0] num_reg;
    logic [1:0]            cnt_reg;
    logic [1:0]            idx_reg;
    logic                  fire;

    assign valid = (cnt_reg != 2'd0);
    assign last  = (idx_reg == cnt_reg - 2'd1);
    assign fire  = valid && ready;
    assign free  = !valid || (fire && last);
    assign kind  = kind_reg[idx_reg];
    // only the first slot can carry a number
    assign num   = (idx_reg == 2'd0) ? num_reg : '0;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg[0] <= toks.kind0;
            kind_reg[1] <= toks.kind1;
            kind_reg[2] <= toks.kind2;
            num_reg     <= toks.num;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end
        else if (load)
        begin
            cnt_reg <= toks.count;
            idx_reg <= 2'd0;
        end
        else if (fire)
        begin
            if (last)
            begin
                cnt_reg <= 2'd0;
                idx_reg <= 2'd0;
            end
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> idx_reg < cnt_reg)
        else $error("token index past count");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("token buffer overwritten");

    a_num_only_on_num: assert property (@(posedge clk) disable iff (!rst_n)
        valid && kind != TK_NUM |-> num == '0)
        else $error("value on a non-number token");

endmodule

@@ rtl/expression_char_lexer.sv @@
`timescale 1ns / 1ps

// channel    dir  tdata                 tuser           tlast
// s_axis     in   [7:0] char_code       [0] action      -
// m_axis     out  [31:0] number_value   [3:0] token_kind last
//
// one request is taken per cycle into an input register while it is
// empty or being stepped; the lexer step runs from there into a three-slot
// token buffer once it is free; a request gives zero to three tokens,
// sent one per cycle while m_axis_tready is high; the single output
// port sets the rate; a request waits in the input register as tokens drain
// reset clears all lexer state and the valid flags of both registers

module expression_char_lexer
    import ecl_pkg::*;
#(
    parameter int NUMBER_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_code
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // number_value
    output logic [3:0]  m_axis_tuser,   // token_kind
    output logic        m_axis_tlast
);

    logic       in_vld_reg;
    logic       action_reg;
    logic [7:0] char_reg;
    logic       step;
    logic       buf_free;
    tok_set_t   toks;

    assign step          = in_vld_reg && buf_free;
    assign s_axis_tready = !in_vld_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (s_axis_tready)
            in_vld_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            action_reg <= s_axis_tuser;
            char_reg   <= s_axis_tdata;
        end
    end

    ecl_core #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .action    (action_reg),
        .char_code (char_reg),
        .toks      (toks)
    );

    ecl_token_buf u_buf (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (step),
        .toks  (toks),
        .free  (buf_free),
        .valid (m_axis_tvalid),
        .ready (m_axis_tready),
        .kind  (m_axis_tuser),
        .num   (m_axis_tdata),
        .last  (m_axis_tlast)
    );

endmodule
